/* sv/pol_pkg.sv */
package pol_pkg;

	localparam int DEPTH  = 16;
	localparam int DATA_W = 32;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int POS_W  = 5;
	// wide enough for position, length and cell index plus one
	localparam int CMP_W  = ((CNT_W > POS_W) ? CNT_W : POS_W) + 2;

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_DELETE = 2'd1;
	localparam logic [1:0] OP_READ   = 2'd2;

	localparam logic [1:0] ST_OK     = 2'd0;
	localparam logic [1:0] ST_BADPOS = 2'd1;
	localparam logic [1:0] ST_FULL   = 2'd2;

	typedef enum logic [1:0] {
		CELL_HOLD,
		CELL_FROM_LEFT,
		CELL_FROM_RIGHT,
		CELL_LOAD
	} cell_sel_t;

	typedef struct packed {
		logic [1:0]  op;
		logic [4:0]  position;
		logic [31:0] value;
	} cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [4:0]  count;
		logic [31:0] element;
		logic        element_valid;
		logic        last;
	} result_t;

endpackage

/* sv/pol_cell.sv */
module pol_cell (
	input  logic                       clk,
	input  pol_pkg::cell_sel_t         sel,
	input  logic [pol_pkg::DATA_W-1:0] left,
	input  logic [pol_pkg::DATA_W-1:0] right,
	input  logic [pol_pkg::DATA_W-1:0] load,
	output logic [pol_pkg::DATA_W-1:0] data
);
	import pol_pkg::*;

	logic [DATA_W-1:0] data_q;

	always_ff @(posedge clk) begin
		case (sel)
			CELL_FROM_LEFT:  data_q <= left;
			CELL_FROM_RIGHT: data_q <= right;
			CELL_LOAD:       data_q <= load;
			default:         data_q <= data_q;
		endcase
	end

	assign data = data_q;

endmodule

/* sv/positional_ordered_list_core.sv */
// Insert, delete and unknown ops: one registered result in the cycle after acceptance; busy stays low,
// so a new transaction can be accepted every cycle.
// Read out: busy while the elements are read out, one element per cycle from the head cell while the
// chain rotates; acceptance enters the READ state, which registers each result. Empty list gives one result.
// The receiver cannot stall: each result strobe lasts exactly one cycle.
// Reset (arst_n low, asynchronous) empties the list; cell contents are not cleared.
module positional_ordered_list_core (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	output logic             busy,
	input  pol_pkg::cmd_t    cmd,
	output logic             result_valid,
	output pol_pkg::result_t result
);
	import pol_pkg::*;

	typedef enum logic {IDLE, READ} state_t;

	state_t            state_q;
	logic [CNT_W-1:0]  length_q;
	logic [CNT_W-1:0]  rd_cnt_q;
	result_t           result_q;
	logic              result_valid_q;

	logic [DATA_W-1:0] cell_data [DEPTH];
	cell_sel_t         cell_sel  [DEPTH];
	logic [DATA_W-1:0] load_data;

	logic              accept;
	logic [CMP_W-1:0]  pos_w, len_w;
	logic              ins_bad, del_bad, full;
	logic              do_ins, do_del, reading, rd_last;

	assign accept  = start && !busy;
	assign pos_w   = CMP_W'(cmd.position);
	assign len_w   = CMP_W'(length_q);
	assign ins_bad = (pos_w == '0) || (pos_w > len_w + CMP_W'(1));
	assign del_bad = (pos_w == '0) || (pos_w > len_w);
	assign full    = (len_w >= CMP_W'(DEPTH));
	assign do_ins  = accept && (cmd.op == OP_INSERT) && !ins_bad && !full;
	assign do_del  = accept && (cmd.op == OP_DELETE) && !del_bad;
	assign reading = (state_q == READ);
	assign rd_last = (CMP_W'(rd_cnt_q) + CMP_W'(1) == len_w);

	// during read out the head wraps around to the tail cell
	assign load_data = reading ? cell_data[0] : DATA_W'(cmd.value);

	for (genvar i = 0; i < DEPTH; i++) begin : g_cell
		logic [CMP_W-1:0]  idx;
		logic [DATA_W-1:0] left_d, right_d;

		assign idx = CMP_W'(i);

		if (i == 0) begin : g_head
			assign left_d = '0;
		end else begin : g_left
			assign left_d = cell_data[i-1];
		end
		if (i == DEPTH - 1) begin : g_tail
			assign right_d = '0;
		end else begin : g_right
			assign right_d = cell_data[i+1];
		end

		always_comb begin
			cell_sel[i] = CELL_HOLD;
			if (do_ins) begin
				if (idx + CMP_W'(1) == pos_w)
					cell_sel[i] = CELL_LOAD;
				else if (idx + CMP_W'(1) > pos_w && idx <= len_w)
					cell_sel[i] = CELL_FROM_LEFT;
			end else if (do_del) begin
				if (idx + CMP_W'(1) >= pos_w && idx + CMP_W'(1) < len_w)
					cell_sel[i] = CELL_FROM_RIGHT;
			end else if (reading) begin
				if (idx + CMP_W'(1) < len_w)
					cell_sel[i] = CELL_FROM_RIGHT;
				else if (idx + CMP_W'(1) == len_w)
					cell_sel[i] = CELL_LOAD;
			end
		end

		pol_cell u_cell (
			.clk   (clk),
			.sel   (cell_sel[i]),
			.left  (left_d),
			.right (right_d),
			.load  (load_data),
			.data  (cell_data[i])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= IDLE;
			length_q       <= '0;
			rd_cnt_q       <= '0;
			result_q       <= '0;
			result_valid_q <= 1'b0;
		end else begin
			result_valid_q <= 1'b0;
			unique case (state_q)
				IDLE: begin
					if (accept) begin
						result_valid_q         <= 1'b1;
						result_q.element       <= '0;
						result_q.element_valid <= 1'b0;
						result_q.last          <= 1'b1;
						result_q.status        <= ST_OK;
						result_q.count         <= 5'(length_q);
						unique case (cmd.op)
							OP_INSERT: begin
								if (ins_bad)
									result_q.status <= ST_BADPOS;
								else if (full)
									result_q.status <= ST_FULL;
								else begin
									length_q       <= length_q + CNT_W'(1);
									result_q.count <= 5'(length_q + CNT_W'(1));
								end
							end
							OP_DELETE: begin
								if (del_bad)
									result_q.status <= ST_BADPOS;
								else begin
									length_q       <= length_q - CNT_W'(1);
									result_q.count <= 5'(length_q - CNT_W'(1));
								end
							end
							OP_READ: begin
								if (length_q != '0) begin
									result_valid_q <= 1'b0;
									rd_cnt_q       <= '0;
									state_q        <= READ;
								end
							end
							default: ;
						endcase
					end
				end
				READ: begin
					result_valid_q         <= 1'b1;
					result_q.status        <= ST_OK;
					result_q.count         <= 5'(length_q);
					result_q.element       <= 32'(cell_data[0]);
					result_q.element_valid <= 1'b1;
					result_q.last          <= rd_last;
					rd_cnt_q               <= rd_cnt_q + CNT_W'(1);
					if (rd_last)
						state_q <= IDLE;
				end
				default: state_q <= IDLE;
			endcase
		end
	end

	assign busy         = reading;
	assign result_valid = result_valid_q;
	assign result       = result_q;

endmodule
